### design/rszl_pkg.sv
// Shared types, constants and helper functions for the row scroll/zoom layer address block.
package rszl_pkg;

  localparam int LAYER_COUNT_DEF = 3;
  localparam int SOURCE_SIZE_DEF = 1024;
  localparam int Q_DEPTH         = 4;
  localparam int CFG_W           = 10;
  localparam int ROW_W           = 10;

  localparam logic [7:0] UNITY_ZOOM = 8'h7f;

  localparam logic CFG_X_OFFSET = 1'b0;
  localparam logic CFG_Y_OFFSET = 1'b1;

  localparam logic [3:0] CTRL_XS_BASE = 4'd0;
  localparam logic [3:0] CTRL_YS_BASE = 4'd3;
  localparam logic [3:0] CTRL_YZ_BASE = 4'd8;

  typedef enum logic [1:0] {
    MODE_CTRL  = 2'd0,
    MODE_ZB    = 2'd1,
    MODE_RS    = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_ZB_WR,
    OP_RS_WR,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       layer;
    logic [ROW_W-1:0] row;
    logic [15:0]      data;
    logic [1:0]       be;
    logic [8:0]       sxp;
    logic [ROW_W-1:0] xbase;
  } rszl_entry_t;

  function automatic logic [14:0] drop_bit4(input logic [15:0] v);
    return {v[15:5], v[3:0]};
  endfunction

  function automatic logic [15:0] merge_bytes(input logic [15:0] old_w,
                                              input logic [15:0] data,
                                              input logic [1:0]  be);
    logic [15:0] v;
    v = old_w;
    if (be[0]) begin
      v[7:0] = data[7:0];
    end
    if (be[1]) begin
      v[15:8] = data[15:8];
    end
    return v;
  endfunction

endpackage

### design/rszl_queue.sv
// Small word queue between the classifying front end and the table back end.
module rszl_queue #(
  parameter int DEPTH = rszl_pkg::Q_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rszl_pkg::rszl_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output rszl_pkg::rszl_entry_t head_entry
);
  import rszl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rszl_entry_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign not_empty  = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
                                  count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### design/rszl_front.sv
// Front end: takes words, applies control and offset writes, forms source row and x base.
module rszl_front #(
  parameter int LAYER_COUNT = rszl_pkg::LAYER_COUNT_DEF,
  parameter int SOURCE_SIZE = rszl_pkg::SOURCE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [1:0]                  in_layer,
  input  logic [3:0]                  in_control_index,
  input  logic [9:0]                  in_row,
  input  logic [15:0]                 in_write_data,
  input  logic [1:0]                  in_byte_enables,
  input  logic [8:0]                  in_screen_x,
  input  logic [8:0]                  in_screen_y,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rszl_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        q_full,
  input  logic                        clr_busy,
  output logic                        push,
  output rszl_pkg::rszl_entry_t       push_entry
);
  import rszl_pkg::*;

  localparam int SRC_W  = $clog2(SOURCE_SIZE);
  localparam int LSEL_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

  logic [CFG_W-1:0] xoff_r, yoff_r;
  logic [15:0]      xs_r [LAYER_COUNT];
  logic [15:0]      ys_r [LAYER_COUNT];
  logic [7:0]       yz_r [LAYER_COUNT];

  logic              accept;
  logic              layer_ok, row_ok;
  logic [LSEL_W-1:0] lsel;
  logic [31:0]       zy_diff, zoom_y, y_fix;
  logic [10:0]       y_pos;
  logic [SRC_W-1:0]  src_row;
  logic [15:0]       neg_xs;
  logic [14:0]       scroll_x;
  logic [SRC_W-1:0]  xbase;

  assign in_stall = q_full || clr_busy;
  assign accept   = in_valid && !in_stall;
  assign layer_ok = (3'(in_layer) < 3'(LAYER_COUNT));
  assign row_ok   = (11'(in_row) < 11'(SOURCE_SIZE));
  assign lsel     = layer_ok ? in_layer[LSEL_W-1:0] : '0;

  // 16.16 source y: scroll plus offset screen line scaled by y zoom
  assign zy_diff  = 32'(yz_r[lsel]) - 32'(UNITY_ZOOM);
  assign zoom_y   = 32'h0001_0000 - (zy_diff << 9);
  assign y_pos    = 11'(yoff_r) + 11'(in_screen_y);
  assign y_fix    = {ys_r[lsel], 16'h0000} + 32'(y_pos) * zoom_y;
  assign src_row  = y_fix[16 +: SRC_W];

  assign neg_xs   = 16'h0000 - xs_r[lsel];
  assign scroll_x = drop_bit4(neg_xs);
  assign xbase    = SRC_W'(scroll_x) + SRC_W'(xoff_r);

  always_comb begin
    push_entry.op    = OP_QUERY;
    push_entry.layer = in_layer;
    push_entry.row   = in_row;
    push_entry.data  = in_write_data;
    push_entry.be    = in_byte_enables;
    push_entry.sxp   = in_screen_x;
    push_entry.xbase = ROW_W'(xbase);
    push             = 1'b0;
    unique case (in_mode)
      MODE_CTRL: begin
        push = 1'b0;
      end
      MODE_ZB: begin
        push_entry.op = OP_ZB_WR;
        push          = accept && layer_ok && row_ok;
      end
      MODE_RS: begin
        push_entry.op = OP_RS_WR;
        push          = accept && layer_ok && row_ok;
      end
      MODE_QUERY: begin
        push_entry.op  = OP_QUERY;
        push_entry.row = ROW_W'(src_row);
        push           = accept && layer_ok;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LAYER_COUNT; l++) begin
        xs_r[l] <= '0;
        ys_r[l] <= '0;
        yz_r[l] <= '0;
      end
    end else if (accept && in_mode == MODE_CTRL) begin
      for (int l = 0; l < LAYER_COUNT; l++) begin
        if (in_control_index == CTRL_XS_BASE + 4'(l)) begin
          xs_r[l] <= merge_bytes(xs_r[l], in_write_data, in_byte_enables);
        end
        if (in_control_index == CTRL_YS_BASE + 4'(l)) begin
          ys_r[l] <= merge_bytes(ys_r[l], in_write_data, in_byte_enables);
        end
        if (in_control_index == CTRL_YZ_BASE + 4'(l) && in_byte_enables[0]) begin
          yz_r[l] <= in_write_data[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xoff_r <= CFG_W'(32);
      yoff_r <= CFG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_OFFSET: xoff_r <= cfg_wdata;
        CFG_Y_OFFSET: yoff_r <= cfg_wdata;
        default:      xoff_r <= xoff_r;
      endcase
    end
  end

endmodule

### design/rszl_back.sv
// Back end: row table memories with clearing pass, table lookup and 16.16 x stepping.
module rszl_back #(
  parameter int LAYER_COUNT = rszl_pkg::LAYER_COUNT_DEF,
  parameter int SOURCE_SIZE = rszl_pkg::SOURCE_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  rszl_pkg::rszl_entry_t q_entry,
  output logic                  pop,
  output logic                  clr_busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [9:0]            out_source_x,
  output logic [9:0]            out_source_y,
  output logic [11:0]           out_color_offset
);
  import rszl_pkg::*;

  localparam int SRC_W  = $clog2(SOURCE_SIZE);
  localparam int DEPTH  = LAYER_COUNT * SOURCE_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] zb_lo_mem [DEPTH];
  logic [7:0] zb_hi_mem [DEPTH];
  logic [7:0] rs_lo_mem [DEPTH];
  logic [7:0] rs_hi_mem [DEPTH];

  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              advance;
  logic [ADDR_W-1:0] q_addr, wr_addr;
  logic [7:0]        wr_lo, wr_hi;
  logic              zb_we_lo, zb_we_hi, rs_we_lo, rs_we_hi;
  logic              is_zb, is_rs, is_query;

  logic [7:0]        zb_lo_rd_r, zb_hi_rd_r, rs_lo_rd_r, rs_hi_rd_r;
  logic              b_valid_r;
  logic [SRC_W-1:0]  b_row_r;
  logic [8:0]        b_sxp_r;
  logic [SRC_W-1:0]  b_xbase_r;

  logic [14:0]       rs_drop;
  logic [SRC_W-1:0]  rs_cols, x_hi;
  logic [16:0]       x_step;
  logic [25:0]       x_prod;
  logic [SRC_W+15:0] x_fix;
  logic [11:0]       color;

  logic              out_valid_r;
  logic [SRC_W-1:0]  out_x_r, out_y_r;
  logic [11:0]       out_color_r;

  assign clr_busy = clr_busy_r;
  assign advance  = !out_valid_r || !out_stall;
  assign pop      = q_valid && advance && !clr_busy_r;
  assign is_zb    = (q_entry.op == OP_ZB_WR);
  assign is_rs    = (q_entry.op == OP_RS_WR);
  assign is_query = (q_entry.op == OP_QUERY);
  assign q_addr   = ADDR_W'({q_entry.layer, q_entry.row[SRC_W-1:0]});

  // clears the entries in turn after reset until every row of every layer is zero
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
        clr_addr_nxt = '0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign wr_addr  = clr_busy_r ? clr_addr_r : q_addr;
  assign wr_lo    = clr_busy_r ? 8'h00 : q_entry.data[7:0];
  assign wr_hi    = clr_busy_r ? 8'h00 : q_entry.data[15:8];
  assign zb_we_lo = clr_busy_r || (pop && is_zb && q_entry.be[0]);
  assign zb_we_hi = clr_busy_r || (pop && is_zb && q_entry.be[1]);
  assign rs_we_lo = clr_busy_r || (pop && is_rs && q_entry.be[0]);
  assign rs_we_hi = clr_busy_r || (pop && is_rs && q_entry.be[1]);

  always_ff @(posedge clk) begin
    if (zb_we_lo) begin
      zb_lo_mem[wr_addr] <= wr_lo;
    end
    if (zb_we_hi) begin
      zb_hi_mem[wr_addr] <= wr_hi;
    end
    if (rs_we_lo) begin
      rs_lo_mem[wr_addr] <= wr_lo;
    end
    if (rs_we_hi) begin
      rs_hi_mem[wr_addr] <= wr_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zb_lo_rd_r <= zb_lo_mem[q_addr];
      zb_hi_rd_r <= zb_hi_mem[q_addr];
      rs_lo_rd_r <= rs_lo_mem[q_addr];
      rs_hi_rd_r <= rs_hi_mem[q_addr];
      b_row_r    <= q_entry.row[SRC_W-1:0];
      b_sxp_r    <= q_entry.sxp;
      b_xbase_r  <= q_entry.xbase[SRC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= pop && is_query;
    end
  end

  // x step = 1.0 + (unity - row zoom) / 256 in 16.16
  assign rs_drop    = drop_bit4({rs_hi_rd_r, rs_lo_rd_r});
  assign rs_cols    = rs_drop[SRC_W-1:0];
  assign x_step     = 17'h10000 + {1'b0, UNITY_ZOOM, 8'h00} - {1'b0, zb_lo_rd_r, 8'h00};
  assign x_prod     = 26'(b_sxp_r) * 26'(x_step);
  assign x_hi       = b_xbase_r - rs_cols;
  assign x_fix      = {x_hi, 16'h0000} + (SRC_W+16)'(x_prod);
  assign color      = {zb_hi_rd_r[7:5], zb_hi_rd_r[3:0], 5'b00000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r     <= x_fix[16 +: SRC_W];
      out_y_r     <= b_row_r;
      out_color_r <= color;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_source_x     = 10'(out_x_r);
  assign out_source_y     = 10'(out_y_r);
  assign out_color_offset = out_color_r;

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n) clr_busy_r |-> !pop)
    else $error("word taken during table clear");
  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
                                   clr_busy_r |-> !out_valid_r && !b_valid_r)
    else $error("result in flight during table clear");
  a_query_moves: assert property (@(posedge clk) disable iff (!rst_n)
                                  pop && is_query |=> b_valid_r)
    else $error("query lost between queue and lookup stage");

endmodule

### design/row_scroll_zoom_layer_address.sv
// Top level of the three-layer row scroll/zoom raster address generator.
//
//   port group | dir     | handshake          | contents
//   in_*       | input   | in_valid/in_stall  | mode, layer, control index, row, data, screen x/y
//   out_*      | output  | out_valid/out_stall| source x, source y, colour offset
//   cfg_*      | input   | cfg_we             | x/y screen offsets
//
// One word is taken per cycle while in_stall is low; a query result leaving the queue is
// registered first in the table read stage and then in the output registers.
// Each row table memory has one write port and one read port.
// After reset the row tables are cleared entry by entry, all LAYER_COUNT*SOURCE_SIZE
// entries (3072 by default), with in_stall high throughout.
// out_stall holds the back end only; the front keeps taking words until the queue fills.
module row_scroll_zoom_layer_address #(
  parameter int LAYER_COUNT = rszl_pkg::LAYER_COUNT_DEF,
  parameter int SOURCE_SIZE = rszl_pkg::SOURCE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic [1:0]                 in_layer,
  input  logic [3:0]                 in_control_index,
  input  logic [9:0]                 in_row,
  input  logic [15:0]                in_write_data,
  input  logic [1:0]                 in_byte_enables,
  input  logic [8:0]                 in_screen_x,
  input  logic [8:0]                 in_screen_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [9:0]                 out_source_x,
  output logic [9:0]                 out_source_y,
  output logic [11:0]                out_color_offset,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [rszl_pkg::CFG_W-1:0] cfg_wdata
);
  import rszl_pkg::*;

  logic        push, pop, q_full, q_valid, clr_busy;
  rszl_entry_t push_entry, head_entry;

  rszl_front #(
    .LAYER_COUNT(LAYER_COUNT),
    .SOURCE_SIZE(SOURCE_SIZE)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_layer         (in_layer),
    .in_control_index (in_control_index),
    .in_row           (in_row),
    .in_write_data    (in_write_data),
    .in_byte_enables  (in_byte_enables),
    .in_screen_x      (in_screen_x),
    .in_screen_y      (in_screen_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_full           (q_full),
    .clr_busy         (clr_busy),
    .push             (push),
    .push_entry       (push_entry)
  );

  rszl_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head_entry (head_entry)
  );

  rszl_back #(
    .LAYER_COUNT(LAYER_COUNT),
    .SOURCE_SIZE(SOURCE_SIZE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (head_entry),
    .pop              (pop),
    .clr_busy         (clr_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_source_x     (out_source_x),
    .out_source_y     (out_source_y),
    .out_color_offset (out_color_offset)
  );

endmodule

### tb/rszl_addr_checker.sv
// Checker for the row scroll/zoom layer address block: mirrors its tables and compares results.
module rszl_addr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_layer,
  input  logic [3:0]  in_control_index,
  input  logic [9:0]  in_row,
  input  logic [15:0] in_write_data,
  input  logic [1:0]  in_byte_enables,
  input  logic [8:0]  in_screen_x,
  input  logic [8:0]  in_screen_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_source_x,
  input  logic [9:0]  out_source_y,
  input  logic [11:0] out_color_offset,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata,
  output int          mismatches,
  output int          outstanding,
  output int          addrs_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rszl_pkg::*;

  localparam int          ROWS    = LAYER_COUNT_DEF * SOURCE_SIZE_DEF;
  localparam logic [31:0] ONE_FIX = 32'h10000;

  typedef struct packed {
    logic [9:0]  sx;
    logic [9:0]  sy;
    logic [11:0] coff;
  } pix_addr_t;

  logic [15:0] ctrl_word [16];
  logic [15:0] zoom_bank [ROWS];
  logic [15:0] scroll_tab [ROWS];
  logic [9:0]  x_off;
  logic [9:0]  y_off;
  pix_addr_t   pending_addrs [$];
  pix_addr_t   want;
  int          entry;

  function automatic logic [15:0] byte_write(input logic [15:0] old_w, input logic [15:0] d,
                                             input logic [1:0] be);
    return {be[1] ? d[15:8] : old_w[15:8], be[0] ? d[7:0] : old_w[7:0]};
  endfunction

  function automatic pix_addr_t locate_pixel(input logic [1:0] lyr, input logic [8:0] sxp,
                                             input logic [8:0] syp);
    logic [15:0] xs_neg;
    logic [15:0] zb;
    logic [15:0] rs;
    logic [31:0] scroll_x;
    logic [31:0] zoom_y;
    logic [31:0] y_acc;
    logic [31:0] step_x;
    logic [31:0] x_acc;
    logic [7:0]  zoom_lo;
    logic [7:0]  bank_byte;
    logic [9:0]  src_row;
    logic [9:0]  row_shift;
    int          idx;
    pix_addr_t   a;
    xs_neg   = 16'h0000 - ctrl_word[CTRL_XS_BASE + lyr];
    scroll_x = 32'({xs_neg[15:5], xs_neg[3:0]});
    zoom_y   = ONE_FIX - ((32'(ctrl_word[CTRL_YZ_BASE + lyr][7:0]) - 32'(UNITY_ZOOM)) << 9);
    y_acc    = (32'(ctrl_word[CTRL_YS_BASE + lyr]) << 16) + (32'(y_off) + 32'(syp)) * zoom_y;
    src_row  = y_acc[25:16];
    idx      = int'(lyr) * SOURCE_SIZE_DEF + int'(src_row);
    zb        = zoom_bank[idx];
    rs        = scroll_tab[idx];
    zoom_lo   = zb[7:0];
    bank_byte = zb[15:8];
    row_shift = {rs[10:5], rs[3:0]};
    step_x = ONE_FIX;
    if (zoom_lo > UNITY_ZOOM) begin
      step_x = step_x - (32'(zoom_lo - UNITY_ZOOM) << 8);
    end else if (zoom_lo < UNITY_ZOOM) begin
      step_x = step_x + (32'(UNITY_ZOOM - zoom_lo) << 8);
    end
    x_acc = (scroll_x << 16) + 32'(x_off) * ONE_FIX - (32'(row_shift) << 16)
            + 32'(sxp) * step_x;
    a.sx   = x_acc[25:16];
    a.sy   = src_row;
    a.coff = {bank_byte[7:5], bank_byte[3:0], 5'b00000};
    return a;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        ctrl_word[i] = '0;
      end
      for (int i = 0; i < ROWS; i++) begin
        zoom_bank[i]  = '0;
        scroll_tab[i] = '0;
      end
      x_off = 10'd32;
      y_off = 10'd16;
      pending_addrs.delete();
      mismatches    = 0;
      addrs_checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_X_OFFSET) begin
          x_off = cfg_wdata;
        end else begin
          y_off = cfg_wdata;
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_addrs.size() == 0) begin
          note_mismatch($sformatf("unexpected word x=%0d y=%0d colour=%0d",
                                  out_source_x, out_source_y, out_color_offset));
        end else begin
          want = pending_addrs.pop_front();
          addrs_checked++;
          if (out_source_x !== want.sx) begin
            note_mismatch($sformatf("source_x %0d, want %0d", out_source_x, want.sx));
          end
          if (out_source_y !== want.sy) begin
            note_mismatch($sformatf("source_y %0d, want %0d", out_source_y, want.sy));
          end
          if (out_color_offset !== want.coff) begin
            note_mismatch($sformatf("color_offset %0d, want %0d", out_color_offset,
                                    want.coff));
          end
        end
      end
      if (in_valid && !in_stall) begin
        entry = int'(in_layer) * SOURCE_SIZE_DEF + int'(in_row);
        case (in_mode)
          MODE_CTRL: begin
            ctrl_word[in_control_index] = byte_write(ctrl_word[in_control_index],
                                                     in_write_data, in_byte_enables);
          end
          MODE_ZB: begin
            if (in_layer < LAYER_COUNT_DEF) begin
              zoom_bank[entry] = byte_write(zoom_bank[entry], in_write_data, in_byte_enables);
            end
          end
          MODE_RS: begin
            if (in_layer < LAYER_COUNT_DEF) begin
              scroll_tab[entry] = byte_write(scroll_tab[entry], in_write_data,
                                             in_byte_enables);
            end
          end
          default: begin
            if (in_layer < LAYER_COUNT_DEF) begin
              pending_addrs.push_back(locate_pixel(in_layer, in_screen_x, in_screen_y));
            end
          end
        endcase
      end
    end
    outstanding = pending_addrs.size();
  end

endmodule

### tb/row_scroll_zoom_layer_address_tb.sv
// Testbench top for the row scroll/zoom layer address block: stimulus, watchdog and verdict.
module row_scroll_zoom_layer_address_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rszl_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    mode_t       mode;
    logic [1:0]  layer;
    logic [3:0]  control_index;
    logic [9:0]  row;
    logic [15:0] write_data;
    logic [1:0]  byte_enables;
    logic [8:0]  screen_x;
    logic [8:0]  screen_y;
  } bus_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [1:0]  in_layer = '0;
  logic [3:0]  in_control_index = '0;
  logic [9:0]  in_row = '0;
  logic [15:0] in_write_data = '0;
  logic [1:0]  in_byte_enables = '0;
  logic [8:0]  in_screen_x = '0;
  logic [8:0]  in_screen_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_source_x;
  logic [9:0]  out_source_y;
  logic [11:0] out_color_offset;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_X_OFFSET;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int   mismatches;
  int   outstanding;
  int   addrs_checked;
  int   words_total = 0;
  int   ctrl_words = 0;
  int   row_words = 0;
  int   query_words = 0;
  int   settings_run = 1;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  logic [9:0] stim_y_off = 10'd16;

  row_scroll_zoom_layer_address u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_layer        (in_layer),
    .in_control_index(in_control_index),
    .in_row          (in_row),
    .in_write_data   (in_write_data),
    .in_byte_enables (in_byte_enables),
    .in_screen_x     (in_screen_x),
    .in_screen_y     (in_screen_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_x    (out_source_x),
    .out_source_y    (out_source_y),
    .out_color_offset(out_color_offset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  rszl_addr_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_layer        (in_layer),
    .in_control_index(in_control_index),
    .in_row          (in_row),
    .in_write_data   (in_write_data),
    .in_byte_enables (in_byte_enables),
    .in_screen_x     (in_screen_x),
    .in_screen_y     (in_screen_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_x    (out_source_x),
    .out_source_y    (out_source_y),
    .out_color_offset(out_color_offset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .addrs_checked   (addrs_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 19);
  endfunction

  always @(negedge clk) begin
    out_stall <= take_break();
  end

  // nothing moving on either channel for too long ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no word moved for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bus_word_t random_word();
    bus_word_t w;
    w.mode          = mode_t'(2'($urandom));
    w.layer         = 2'($urandom);
    w.control_index = 4'($urandom);
    w.row           = 10'($urandom);
    w.write_data    = 16'($urandom);
    w.byte_enables  = 2'($urandom);
    w.screen_x      = 9'($urandom);
    w.screen_y      = 9'($urandom);
    return w;
  endfunction

  function automatic bus_word_t mk(input mode_t m, input logic [1:0] lyr, input logic [3:0] ci,
                                   input logic [9:0] r, input logic [15:0] d,
                                   input logic [1:0] be, input logic [8:0] sx,
                                   input logic [8:0] sy);
    bus_word_t w;
    w.mode          = m;
    w.layer         = lyr;
    w.control_index = ci;
    w.row           = r;
    w.write_data    = d;
    w.byte_enables  = be;
    w.screen_x      = sx;
    w.screen_y      = sy;
    return w;
  endfunction

  task automatic send_word(input bus_word_t w);
    @(negedge clk);
    while (take_break()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_mode          = w.mode;
    in_layer         = w.layer;
    in_control_index = w.control_index;
    in_row           = w.row;
    in_write_data    = w.write_data;
    in_byte_enables  = w.byte_enables;
    in_screen_x      = w.screen_x;
    in_screen_y      = w.screen_y;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    words_total++;
    case (w.mode)
      MODE_CTRL:  ctrl_words++;
      MODE_QUERY: query_words++;
      default:    row_words++;
    endcase
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    // writes may still sit in the queue behind the last result
    repeat (16) @(negedge clk);
  endtask

  task automatic set_offsets(input logic [9:0] xo, input logic [9:0] yo);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_X_OFFSET;
    cfg_wdata = xo;
    @(negedge clk);
    cfg_index = CFG_Y_OFFSET;
    cfg_wdata = yo;
    @(negedge clk);
    cfg_we     = 1'b0;
    stim_y_off = yo;
    settings_run++;
  endtask

  // set up one layer, fill the rows its queries land on at unity y zoom, then query them
  task automatic play_scene();
    logic [1:0]  lyr;
    logic [15:0] ys;
    logic [8:0]  sy0;
    int          nrows;
    int          nq;
    bus_word_t   w;
    lyr = 2'($urandom_range(2));
    w = random_word();
    w.mode          = MODE_CTRL;
    w.control_index = CTRL_XS_BASE + lyr;
    w.byte_enables  = 2'b11;
    send_word(w);
    ys = 16'($urandom);
    w = random_word();
    w.mode          = MODE_CTRL;
    w.control_index = CTRL_YS_BASE + lyr;
    w.write_data    = ys;
    w.byte_enables  = 2'b11;
    send_word(w);
    w = random_word();
    w.mode          = MODE_CTRL;
    w.control_index = CTRL_YZ_BASE + lyr;
    w.byte_enables  = 2'b11;
    if ($urandom_range(9) < 7) begin
      w.write_data[7:0] = UNITY_ZOOM;
    end
    send_word(w);
    sy0   = 9'($urandom_range(504));
    nrows = $urandom_range(2, 6);
    for (int k = 0; k < nrows; k++) begin
      w = random_word();
      w.mode  = MODE_ZB;
      w.layer = lyr;
      w.row   = 10'(32'(ys) + 32'(stim_y_off) + 32'(sy0) + k);
      if ($urandom_range(3) != 0) begin
        w.byte_enables = 2'b11;
      end
      send_word(w);
      w.mode         = MODE_RS;
      w.write_data   = 16'($urandom);
      w.byte_enables = ($urandom_range(3) != 0) ? 2'b11 : 2'($urandom);
      send_word(w);
    end
    nq = $urandom_range(3, 8);
    for (int k = 0; k < nq; k++) begin
      w = random_word();
      w.mode     = MODE_QUERY;
      w.layer    = lyr;
      w.screen_y = sy0 + 9'($urandom_range(nrows - 1));
      send_word(w);
      if ($urandom_range(19) == 0) begin
        send_word(random_word());
      end
    end
  endtask

  initial begin
    logic [9:0] xo;
    logic [9:0] yo;
    int         start;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed words at the reset offsets
    send_word(mk(MODE_QUERY, 2'd0, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd0, 9'd0));
    send_word(mk(MODE_QUERY, 2'd2, 4'd15, 10'd1023, 16'hffff, 2'b11, 9'd511, 9'd511));
    send_word(mk(MODE_QUERY, 2'd3, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd100, 9'd100));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_XS_BASE, 10'd0, 16'hffff, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_YS_BASE + 4'd1, 10'd0, 16'h1234, 2'b01, 9'd0, 9'd0));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_YS_BASE + 4'd1, 10'd0, 16'hffff, 2'b00, 9'd0, 9'd0));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_YZ_BASE, 10'd0, 16'h0000, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_YZ_BASE + 4'd2, 10'd0, 16'h00ff, 2'b01, 9'd0, 9'd0));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_YZ_BASE + 4'd1, 10'd0, 16'h007f, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_CTRL, 2'd3, 4'd15, 10'd1023, 16'hffff, 2'b11, 9'd511, 9'd511));
    send_word(mk(MODE_CTRL, 2'd0, CTRL_XS_BASE + 4'd2, 10'd0, 16'h0010, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_ZB, 2'd0, 4'd0, 10'd0, 16'hff00, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_RS, 2'd0, 4'd0, 10'd0, 16'hffff, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_ZB, 2'd2, 4'd0, 10'd1023, 16'h00ff, 2'b01, 9'd0, 9'd0));
    send_word(mk(MODE_RS, 2'd1, 4'd0, 10'd1023, 16'h0010, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_ZB, 2'd3, 4'd0, 10'd5, 16'hffff, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_RS, 2'd3, 4'd0, 10'd5, 16'hffff, 2'b11, 9'd0, 9'd0));
    send_word(mk(MODE_ZB, 2'd1, 4'd0, 10'd512, 16'hffff, 2'b00, 9'd0, 9'd0));
    send_word(mk(MODE_QUERY, 2'd0, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd0, 9'd0));
    send_word(mk(MODE_QUERY, 2'd0, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd511, 9'd511));
    send_word(mk(MODE_QUERY, 2'd1, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd255, 9'd0));
    send_word(mk(MODE_QUERY, 2'd2, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd511, 9'd0));
    send_word(mk(MODE_QUERY, 2'd1, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd0, 9'd511));
    send_word(mk(MODE_QUERY, 2'd3, 4'd0, 10'd0, 16'h0000, 2'b00, 9'd511, 9'd511));
    wait_quiet();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          xo = 10'd0;
          yo = 10'd0;
        end
        1: begin
          xo = 10'd1023;
          yo = 10'd1023;
        end
        default: begin
          xo = 10'($urandom);
          yo = 10'($urandom);
        end
      endcase
      set_offsets(xo, yo);
      calm  = (p == 2);
      start = words_total;
      while (words_total - start < 80) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 3)) send_word(random_word());
        end else begin
          play_scene();
        end
      end
      calm = 1'b0;
      wait_quiet();
    end

    $display("%0d bus words sent: %0d control, %0d row table, %0d pixel queries",
             words_total, ctrl_words, row_words, query_words);
    $display("%0d offset settings, %0d addresses checked, %0d mismatches, %0d never arrived",
             settings_run, addrs_checked, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
